// ===== src/dtfp_pkg.sv =====
package dtfp_pkg;

   // widths and limits
   localparam int MAX_SCALE = 18;
   localparam int SCALE_W   = 5;
   localparam int ACC_W     = 64;
   localparam int STEP_W    = ACC_W + 4;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int QCNT_W    = 3;

   localparam logic [SCALE_W-1:0] FRAC_SCALE_RST = 5'd2;
   localparam logic [SCALE_W-1:0] SCALE_LIMIT    = SCALE_W'(MAX_SCALE);
   localparam logic [ACC_W-1:0]   I64_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;

   // character codes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_NO_DIGITS  = 3'd2,
      ST_TWO_POINTS = 3'd3,
      ST_NON_DIGIT  = 3'd4,
      ST_PRECISION  = 3'd5,
      ST_RANGE      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,
      PH_BODY  = 2'd1,
      PH_TRAIL = 2'd2
   } phase_type;

   typedef enum logic {
      BK_RUN = 1'b0,
      BK_PAD = 1'b1
   } back_state_type;

   // one work item from the parser to the accumulator
   typedef struct packed {
      logic               push;
      logic [3:0]         digit;
      logic               finish;
      status_type         status;
      logic               negative;
      logic [SCALE_W-1:0] pad;
   } token_type;

endpackage

// ===== src/decimal_text_to_fixed_point.sv =====
// end of text: a beat with tlast is queued as a token; the accumulator pops it, then pads P
//   zero fraction digits (0 to 18), one per cycle, before it registers the result
// throughput: one character beat per cycle while the token queue is not full; each end of text
//   holds the accumulator while it pads and waits for a free result register, absorbed by a four-entry token queue
// reset: synchronous, active high; clears parse state, queue, accumulator and result valid, frac_scale returns to 2
module decimal_text_to_fixed_point import dtfp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] char_code
   input  logic               req_tuser,   // [0] has_char
   input  logic               req_tlast,   // last_item
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,   // [63:0] scaled_value
   output logic [2:0]         rsp_tuser,   // [2:0] status
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SCALE_W-1:0] csr_data     // frac_scale
);

   logic       q_push;
   token_type  q_in_token;
   logic       q_full;
   logic       q_pop;
   logic       q_valid;
   token_type  q_head;
   status_type status;

   dtfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_token    (q_in_token)
   );

   dtfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_in_token),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_token (q_head)
   );

   dtfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_token    (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_status (status)
   );

   assign rsp_tuser = status;

endmodule

// ===== src/dtfp_front.sv =====
module dtfp_front import dtfp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // char_code
   input  logic               req_tuser,   // has_char
   input  logic               req_tlast,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SCALE_W-1:0] csr_data,    // frac_scale
   input  logic               q_full,
   output logic               q_push,
   output token_type          q_token
);

   logic [SCALE_W-1:0] scale_ff, scale_in;
   phase_type          phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic               digit_ff, digit_in;
   logic               point_ff, point_in;
   logic [SCALE_W-1:0] frac_ff, frac_in;
   status_type         err_ff, err_in;

   logic               accept;
   logic               is_space;
   logic               is_digit;
   logic               is_sign;
   logic               body;
   logic               push;
   logic [SCALE_W-1:0] scale;
   status_type         fin_status;
   logic [SCALE_W-1:0] fin_pad;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   // character classes and effective scale
   assign is_space = (req_tdata == CH_SPACE) || (req_tdata == CH_TAB) ||
                     (req_tdata == CH_LF) || (req_tdata == CH_CR);
   assign is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
   assign is_sign  = (req_tdata == CH_PLUS) || (req_tdata == CH_MINUS);
   assign scale    = (scale_ff > SCALE_LIMIT) ? SCALE_LIMIT : scale_ff;

   // parse state update for one character
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      digit_in = digit_ff;
      point_in = point_ff;
      frac_in  = frac_ff;
      err_in   = err_ff;
      body     = 1'b0;
      push     = 1'b0;
      if (req_tuser) begin
         if (is_space) begin
            if (phase_ff == PH_BODY) begin
               phase_in = PH_TRAIL;
            end
         end else if (phase_ff == PH_LEAD) begin
            phase_in = PH_BODY;
            if (is_sign) begin
               neg_in = (req_tdata == CH_MINUS);
            end else begin
               body = (err_ff == ST_OK);
            end
         end else begin
            // whitespace inside the number
            if ((phase_ff == PH_TRAIL) && (err_ff == ST_OK)) begin
               err_in = ST_NON_DIGIT;
            end
            phase_in = PH_BODY;
            body     = (err_in == ST_OK);
         end
      end
      if (body) begin
         if (req_tdata == CH_POINT) begin
            if (point_ff) begin
               err_in = ST_TWO_POINTS;
            end else begin
               point_in = 1'b1;
            end
         end else if (!is_digit) begin
            err_in = ST_NON_DIGIT;
         end else begin
            digit_in = 1'b1;
            if (point_ff) begin
               if (frac_ff >= scale) begin
                  // surplus fraction digits must be zero
                  if (req_tdata[3:0] != 4'd0) begin
                     err_in = ST_PRECISION;
                  end
               end else begin
                  frac_in = frac_ff + 1'b1;
                  push    = 1'b1;
               end
            end else begin
               push = 1'b1;
            end
         end
      end
   end

   // end of text status and padding count
   always_comb begin
      fin_pad = '0;
      if (phase_in == PH_LEAD) begin
         fin_status = ST_EMPTY;
      end else if (err_in != ST_OK) begin
         fin_status = err_in;
      end else if (!digit_in) begin
         fin_status = ST_NO_DIGITS;
      end else begin
         fin_status = ST_OK;
         if (scale > frac_in) begin
            fin_pad = scale - frac_in;
         end
      end
   end

   // token to the queue
   always_comb begin
      q_push           = accept && (push || req_tlast);
      q_token.push     = push;
      q_token.digit    = req_tdata[3:0];
      q_token.finish   = req_tlast;
      q_token.status   = fin_status;
      q_token.negative = neg_in;
      q_token.pad      = fin_pad;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= FRAC_SCALE_RST;
      end else if (csr_valid) begin
         scale_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         phase_ff <= PH_LEAD;
         neg_ff   <= 1'b0;
         digit_ff <= 1'b0;
         point_ff <= 1'b0;
         frac_ff  <= '0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         digit_ff <= digit_in;
         point_ff <= point_in;
         frac_ff  <= frac_in;
         err_ff   <= err_in;
      end
   end

   // fraction count never runs past the largest scale
   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      frac_ff <= SCALE_LIMIT)
      else $error("fraction count above limit");

endmodule

// ===== src/dtfp_queue.sv =====
module dtfp_queue import dtfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output token_type head_token
);

   token_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count above depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");

endmodule

// ===== src/dtfp_back.sv =====
module dtfp_back import dtfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  token_type        q_token,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [ACC_W-1:0] rsp_value,
   output status_type       rsp_status
);

   back_state_type     state_ff, state_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic [SCALE_W-1:0] cnt_ff, cnt_in;
   status_type         stat_ff, stat_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]   rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               slot_free;
   logic               step_en;
   logic [3:0]         step_digit;
   logic [STEP_W-1:0]  step_sum;
   logic               step_ovf;
   logic               emit;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // times ten plus digit, saturating at int64 max
   assign step_sum = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + STEP_W'(step_digit);
   assign step_ovf = step_sum > {4'b0, I64_MAX};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_RUN: begin
            if (q_valid && q_token.finish) begin
               state_in = BK_PAD;
            end
         end
         BK_PAD: begin
            if ((cnt_ff == '0) && slot_free) begin
               state_in = BK_RUN;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   // datapath control
   always_comb begin
      q_pop      = 1'b0;
      step_en    = 1'b0;
      step_digit = 4'd0;
      emit       = 1'b0;
      cnt_in     = cnt_ff;
      stat_in    = stat_ff;
      neg_in     = neg_ff;
      case (state_ff)
         BK_RUN: begin
            q_pop = q_valid;
            if (q_valid) begin
               step_en    = q_token.push;
               step_digit = q_token.digit;
               if (q_token.finish) begin
                  cnt_in  = q_token.pad;
                  stat_in = q_token.status;
                  neg_in  = q_token.negative;
               end
            end
         end
         BK_PAD: begin
            if (cnt_ff != '0) begin
               // one zero of padding per cycle
               step_en = 1'b1;
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               emit = slot_free;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // accumulator update
   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (emit) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (step_en) begin
         if (step_ovf) begin
            acc_in = I64_MAX;
            ovf_in = 1'b1;
         end else begin
            acc_in = step_sum[ACC_W-1:0];
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (stat_ff != ST_OK) begin
            rsp_status_in = stat_ff;
            rsp_value_in  = '0;
         end else if (ovf_ff) begin
            rsp_status_in = ST_RANGE;
            rsp_value_in  = '0;
         end else begin
            rsp_status_in = ST_OK;
            rsp_value_in  = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff       <= stat_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // magnitude saturates below the sign bit
   a_acc_sat: assert property (@(posedge clock) disable iff (reset)
      !acc_ff[ACC_W-1])
      else $error("magnitude above int64 max");

   // any failing status carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_value_ff == '0))
      else $error("nonzero value with error status");

endmodule

// ===== bench/dtfp_checker.sv =====
module dtfp_checker import dtfp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] char_code
   input  logic               req_tuser,   // [0] has_char
   input  logic               req_tlast,   // last_item
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [63:0]        rsp_tdata,   // [63:0] scaled_value
   input  logic [2:0]         rsp_tuser,   // [2:0] status
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [SCALE_W-1:0] csr_data,    // frac_scale
   output int                 fail_count,
   output int                 pending_results,
   output int                 results_checked
);

   typedef struct packed {
      logic [63:0] value;
      status_type  status;
   } fixed_result_type;

   // predicted results in arrival order
   fixed_result_type expected_values [$];

   // shadow of the register and of the parse state
   logic [SCALE_W-1:0] frac_scale_q;
   logic [ACC_W-1:0]   mag_acc;
   logic               ovf_seen;
   phase_type          phase;
   logic               neg_flag;
   logic               digit_seen;
   logic               point_seen;
   logic [SCALE_W-1:0] frac_cnt;
   status_type         first_err;

   task automatic clear_text();
      mag_acc    = '0;
      ovf_seen   = 1'b0;
      phase      = PH_LEAD;
      neg_flag   = 1'b0;
      digit_seen = 1'b0;
      point_seen = 1'b0;
      frac_cnt   = '0;
      first_err  = ST_OK;
   endtask

   // times ten plus digit, saturating at int64 max
   task automatic shift_in_digit(input logic [3:0] d);
      if (mag_acc > (I64_MAX - {60'd0, d}) / 64'd10) begin
         ovf_seen = 1'b1;
         mag_acc  = I64_MAX;
      end else begin
         mag_acc = mag_acc * 64'd10 + {60'd0, d};
      end
   endtask

   // one character beat into the parse state, result on the end of text
   task automatic parse_char(input logic [7:0] c, input logic has, input logic last);
      logic [SCALE_W-1:0] scale;
      logic               is_space;
      logic               take_body;
      fixed_result_type   res;
      int                 k;
      scale     = (frac_scale_q > SCALE_LIMIT) ? SCALE_LIMIT : frac_scale_q;
      is_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
      take_body = 1'b0;
      // whitespace phase and sign
      if (has && is_space) begin
         if (phase == PH_BODY) phase = PH_TRAIL;
      end else if (has) begin
         if (phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
            neg_flag = (c == CH_MINUS);
         end else begin
            // whitespace inside the number
            if (phase == PH_TRAIL && first_err == ST_OK) first_err = ST_NON_DIGIT;
            take_body = (first_err == ST_OK);
         end
         phase = PH_BODY;
      end
      // point, digits and the rest
      if (take_body) begin
         if (c == CH_POINT) begin
            if (point_seen) first_err = ST_TWO_POINTS;
            else point_seen = 1'b1;
         end else if (c < CH_ZERO || c > CH_NINE) begin
            first_err = ST_NON_DIGIT;
         end else begin
            digit_seen = 1'b1;
            if (point_seen && frac_cnt >= scale) begin
               // surplus fraction digit must be zero
               if (c[3:0] != 4'd0) first_err = ST_PRECISION;
            end else begin
               if (point_seen) frac_cnt = frac_cnt + 1'b1;
               shift_in_digit(c[3:0]);
            end
         end
      end
      // end of text
      if (last) begin
         res.value = '0;
         if (phase == PH_LEAD) begin
            res.status = ST_EMPTY;
         end else if (first_err != ST_OK) begin
            res.status = first_err;
         end else if (!digit_seen) begin
            res.status = ST_NO_DIGITS;
         end else begin
            for (k = 0; k < MAX_SCALE && frac_cnt < scale; k++) begin
               shift_in_digit(4'd0);
               frac_cnt = frac_cnt + 1'b1;
            end
            res.status = ovf_seen ? ST_RANGE : ST_OK;
            if (!ovf_seen) res.value = neg_flag ? (64'd0 - mag_acc) : mag_acc;
         end
         expected_values.push_back(res);
         clear_text();
      end
   endtask

   always @(posedge clock) begin : track
      fixed_result_type want;
      if (reset) begin
         clear_text();
         frac_scale_q = FRAC_SCALE_RST;
         expected_values.delete();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         // result beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               $error("result with nothing expected: scaled_value %0d, status %0d",
                      $signed(rsp_tdata), rsp_tuser);
               fail_count++;
            end else begin
               want = expected_values.pop_front();
               results_checked++;
               if (rsp_tdata !== want.value) begin
                  $error("scaled_value: expected %0d, got %0d",
                         $signed(want.value), $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) parse_char(req_tdata, req_tuser, req_tlast);
         if (csr_valid && csr_ready) frac_scale_q = csr_data;
      end
   end

   // queue depth, read away from the rising edge
   always @(negedge clock) pending_results <= expected_values.size();

endmodule

// ===== bench/tb_decimal_text_to_fixed_point.sv =====
module tb_decimal_text_to_fixed_point;
   import dtfp_pkg::*;

   localparam int RANDOM_ITEMS  = 520;
   localparam int SETTLE_CYCLES = 30;
   localparam int LONG_HOLD     = 400;
   localparam int IDLE_LIMIT    = 3000;

   typedef enum int {
      END_ON_CHAR,
      END_BARE,
      END_NONE
   } text_end_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata = 8'd0;   // [7:0] char_code
   logic               req_tuser = 1'b0;   // [0] has_char
   logic               req_tlast = 1'b0;   // last_item
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [63:0]        rsp_tdata;          // [63:0] scaled_value
   logic [2:0]         rsp_tuser;          // [2:0] status
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [SCALE_W-1:0] csr_data = '0;      // frac_scale

   int fail_count;
   int pending_results;
   int results_checked;

   int         beats_sent   = 0;
   int         scale_writes = 0;
   int         cur_scale    = 2;
   int         holds_asked  = 0;
   int         holds_served = 0;
   bit         tx_calm      = 1'b0;
   bit         rx_calm      = 1'b0;
   logic [7:0] text_q [$];
   int         scale_plan [0:6] = '{0, 18, 31, 5, 1, 12, 3};

   decimal_text_to_fixed_point dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   dtfp_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   // one request beat, with an optional gap in front
   task automatic send_beat(input logic [7:0] c, input logic has, input logic last);
      int gap;
      if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= has;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // text_q as character beats, with stray bare markers now and then
   task automatic send_text(input text_end_type end_mode);
      int i;
      for (i = 0; i < text_q.size(); i++) begin
         if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(text_q[i], 1'b1, end_mode == END_ON_CHAR && i == text_q.size() - 1);
      end
      if (end_mode == END_BARE || (end_mode == END_ON_CHAR && text_q.size() == 0))
         send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic send_str(input string s, input text_end_type end_mode);
      int i;
      text_q.delete();
      for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_text(end_mode);
   endtask

   // sender pause until every result is back and the block has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input int v);
      csr_valid <= 1'b1;
      csr_data  <= SCALE_W'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_scale = v;
      scale_writes++;
   endtask

   // random number text, mostly well formed
   task automatic build_text();
      string near_max;
      int    eff;
      int    r;
      int    n_int;
      int    n_frac;
      int    k;
      near_max = "922337203685477580";
      eff = (cur_scale > MAX_SCALE) ? MAX_SCALE : cur_scale;
      r = $urandom_range(0, 99);
      text_q.delete();
      repeat ($urandom_range(0, 2)) text_q.push_back(pick_space());
      if (r < 6) begin
         // around int64 max
         if ($urandom_range(0, 1)) text_q.push_back(CH_MINUS);
         for (k = 0; k < near_max.len(); k++) text_q.push_back(near_max[k]);
         text_q.push_back(CH_ZERO + 8'($urandom_range(6, 9)));
      end else begin
         case ($urandom_range(0, 3))
            0: text_q.push_back(CH_PLUS);
            1: text_q.push_back(CH_MINUS);
            default: ;
         endcase
         n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
         repeat (n_int) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 2) != 0) begin
            text_q.push_back(CH_POINT);
            n_frac = $urandom_range(0, eff + 2);
            // surplus fraction digits are mostly zero
            for (k = 0; k < n_frac; k++) begin
               if (k >= eff && $urandom_range(0, 3) != 0) text_q.push_back(CH_ZERO);
               else text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
         end
      end
      repeat ($urandom_range(0, 2)) text_q.push_back(pick_space());
      // broken texts
      if (r >= 75) begin
         case ($urandom_range(0, 4))
            0: text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
            1: text_q.insert($urandom_range(0, text_q.size()), CH_POINT);
            2: text_q.insert($urandom_range(0, text_q.size()), pick_space());
            3: text_q.insert($urandom_range(0, text_q.size()),
                             $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            default: begin
               text_q.delete();
               repeat ($urandom_range(1, 3)) text_q.push_back(pick_space());
            end
         endcase
      end
   endtask

   // receiver: random ready, calm stretches, long holds on request
   initial begin : rx_side
      int gap_left;
      int k;
      gap_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_tready <= 1'b0;
            for (k = 0; k < LONG_HOLD; k++) @(posedge clock);
         end else if (gap_left > 0) begin
            rsp_tready <= 1'b0;
            gap_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!rx_calm) gap_left = pick_gap();
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   initial begin : watchdog
      int idle;
      idle = 0;
      @(negedge reset);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase_n;
      int random_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed texts at the reset scale
      send_beat(8'h00, 1'b0, 1'b1);           // bare end: empty
      send_str("-", END_ON_CHAR);             // sign only: no digits
      send_str("..", END_ON_CHAR);            // two points
      send_beat(8'hFF, 1'b1, 1'b1);           // high byte: non-digit
      send_str("1 2", END_ON_CHAR);           // inner whitespace
      send_str("5-", END_ON_CHAR);            // late sign
      send_beat(8'hA5, 1'b0, 1'b0);           // bare marker, no result
      send_str("-.120\n", END_ON_CHAR);       // zero surplus digit dropped
      send_str(".005", END_ON_CHAR);          // nonzero surplus digit
      wait_idle();
      write_scale(18);
      send_str("10", END_ON_CHAR);            // padding overflows
      send_str("9", END_ON_CHAR);             // full padding, fits
      wait_idle();
      write_scale(4);
      send_str("1.23", END_NONE);             // scale drops mid-text
      wait_idle();
      write_scale(1);
      send_str("\t", END_ON_CHAR);

      // random phases, one scale each
      random_start = beats_sent;
      phase_n = 0;
      while (beats_sent - random_start < RANDOM_ITEMS) begin
         wait_idle();
         write_scale(phase_n < 7 ? scale_plan[phase_n] : $urandom_range(0, 31));
         // receiver holds off while texts keep coming
         if (phase_n == 1) holds_asked++;
         repeat ($urandom_range(8, 16)) begin
            if (beats_sent - random_start < RANDOM_ITEMS) begin
               build_text();
               send_text($urandom_range(0, 5) == 0 ? END_BARE : END_ON_CHAR);
            end
         end
         phase_n++;
      end

      wait_idle();
      $display("sent %0d character beats under %0d scale settings, with a long result hold",
               beats_sent, scale_writes);
      $display("checked %0d results for scaled value and status", results_checked);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
